@@ sv/rmv_pkg.sv @@
// Package for the running mean and variance core.
// Holds sequencer state codes and fixed field widths; no dependencies.
package rmv_pkg;
    localparam int MEAN_W = 32;
    localparam int SUM_W  = 64;
    localparam int VAR_W  = 40;
    localparam int SD_W   = 24;
    localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIVM = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIVV = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
endpackage

@@ sv/running_mean_variance_core.sv @@
// Running mean and variance core (Welford update), fixed point.
// Uses rmv_pkg for state codes and widths.
//
// channel | dir | fields (low bit first)
// s_axis  | in  | tuser: mode; tdata: sample[15:0]
// m_axis  | out | count[23:0] mean[55:24] variance[95:56] stdev[119:96]
//         |     | minimum[135:120] maximum[151:136] last_value[167:152] overflow[168]
// An add goes from accept to result through a restoring divide for the mean step,
// the mean update, the product and the sum, a restoring divide for the variance
// and a root.
// Clear, overflow and first-sample items go straight to the variance divide.
// Reset clears all statistics; s_axis_tready is low from accept to result taken.
module running_mean_variance_core #(
    parameter int COUNT_BITS  = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic         s_axis_tuser,  // mode
    input  logic [15:0]  s_axis_tdata,  // sample[15:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [175:0] m_axis_tdata   // count, mean, variance, stdev, min, max, last, overflow
);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [2:0]  r_st;
    logic [6:0]  r_it;
    logic [COUNT_BITS-1:0] r_cnt;
    logic signed [31:0] r_mean;
    logic [63:0] r_sum;
    logic signed [SAMPLE_BITS-1:0] r_min, r_max, r_last;
    logic        r_ovf;
    // shared divider / root state
    logic [63:0] r_q;        // dividend shifting into quotient
    logic [64:0] r_rem;
    logic [63:0] r_den;
    logic        r_qneg;
    logic signed [47:0] r_d1;
    logic signed [47:0] r_x;
    logic [rmv_pkg::VAR_W-1:0] r_var;
    logic [rmv_pkg::SD_W-1:0]  r_sd;
    logic [175:0] r_out;

    logic [64:0] w_trial;
    logic [64:0] w_rs;
    logic signed [47:0] w_nm;
    logic signed [47:0] w_d2;
    logic [31:0] w_m1, w_m2;
    logic [63:0] w_prod;
    logic [63:0] w_p;
    logic [64:0] w_sadd;
    logic [63:0] w_var64;
    logic [49:0] w_rtrial;
    logic [49:0] w_rnext;
    logic [23:0] w_raw;
    logic signed [SAMPLE_BITS-1:0] w_smp;

    assign w_raw  = {8'd0, s_axis_tdata};
    assign w_smp  = w_raw[SAMPLE_BITS-1:0];
    assign w_rs   = {r_rem[63:0], r_q[63]};
    assign w_trial = w_rs - {1'b0, r_den};
    assign w_nm = 48'(r_mean)
                  + (r_qneg ? -$signed({1'b0, r_q[46:0]}) : $signed({1'b0, r_q[46:0]}));
    assign w_d2 = r_x - {{16{r_mean[31]}}, r_mean};
    assign w_m1 = r_d1[47] ? 32'(-r_d1) : 32'(r_d1);
    assign w_m2 = w_d2[47] ? 32'(-w_d2) : 32'(w_d2);
    assign w_prod = w_m1 * w_m2;
    assign w_p = {24'd0, r_q[63:24]};
    assign w_sadd = {1'b0, r_sum} + {1'b0, w_p};
    assign w_var64 = r_q;
    // root: r_rem holds remaining radicand bits, r_q[49:0] partial remainder
    assign w_rtrial = {r_q[47:0], r_rem[47:46]} - {24'd0, r_sd, 2'b01};
    assign w_rnext  = {r_q[47:0], r_rem[47:46]};

    logic r_mv;
    assign m_axis_tvalid = r_mv;

    assign s_axis_tready = (r_st == rmv_pkg::ST_IDLE) && !m_axis_tvalid;
    assign m_axis_tdata = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= rmv_pkg::ST_IDLE;
            r_mv <= 1'b0;
            r_cnt <= '0; r_mean <= '0; r_sum <= '0;
            r_min <= '0; r_max <= '0; r_last <= '0; r_ovf <= 1'b0;
        end else begin
            if (r_mv && m_axis_tready) r_mv <= 1'b0;
            case (r_st)
                rmv_pkg::ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_ovf <= 1'b0;
                        if (s_axis_tuser) begin
                            r_cnt <= '0; r_mean <= '0; r_sum <= '0;
                            r_min <= '0; r_max <= '0; r_last <= '0;
                            r_st <= rmv_pkg::ST_DIVV; r_it <= 7'd0;
                            r_q <= '0; r_rem <= '0; r_den <= 64'd1;
                        end else if (r_cnt == CNT_MAX) begin
                            r_ovf <= 1'b1;
                            r_st <= rmv_pkg::ST_DIVV; r_it <= 7'd0;
                            r_q <= r_sum; r_rem <= '0;
                            r_den <= 64'(r_cnt - 1'b1);
                        end else begin
                            r_last <= w_smp;
                            r_cnt <= r_cnt + 1'b1;
                            if (r_cnt == '0) begin
                                r_min <= w_smp; r_max <= w_smp;
                                r_mean <= 32'(signed'(w_smp)) <<< 16;
                                r_sum <= '0;
                                r_st <= rmv_pkg::ST_DIVV; r_it <= 7'd0;
                                r_q <= '0; r_rem <= '0; r_den <= 64'd1;
                            end else begin
                                if (w_smp > r_max) r_max <= w_smp;
                                else if (w_smp < r_min) r_min <= w_smp;
                                r_x <= 48'(signed'(w_smp)) <<< 16;
                                r_d1 <= (48'(signed'(w_smp)) <<< 16)
                                        - {{16{r_mean[31]}}, r_mean};
                                r_st <= rmv_pkg::ST_DIVM; r_it <= 7'd127;
                            end
                        end
                    end
                end
                rmv_pkg::ST_DIVM: begin
                    if (r_it == 7'd127) begin
                        r_qneg <= r_d1[47];
                        r_q <= {32'd0, w_m1};
                        r_rem <= '0;
                        r_den <= 64'(r_cnt);
                        r_it <= 7'd0;
                    end else begin
                        r_rem <= w_trial[64] ? w_rs : w_trial;
                        r_q <= {r_q[62:0], ~w_trial[64]};
                        if (r_it == 7'd63) begin
                            r_st <= rmv_pkg::ST_MUL;
                        end else begin
                            r_it <= r_it + 1'b1;
                        end
                    end
                end
                rmv_pkg::ST_MUL: begin
                    if (w_nm > 48'sh7FFF_FFFF) r_mean <= 32'h7FFF_FFFF;
                    else if (w_nm < -48'sh8000_0000) r_mean <= 32'h8000_0000;
                    else r_mean <= w_nm[31:0];
                    r_st <= rmv_pkg::ST_SQRT; r_it <= 7'd127;
                end
                rmv_pkg::ST_SQRT: begin
                    if (r_it == 7'd127) begin
                        // product phase, mean now updated
                        r_q <= w_prod;
                        r_qneg <= r_d1[47] != w_d2[47];
                        r_it <= 7'd126;
                    end else if (r_it == 7'd126) begin
                        if (r_qneg)
                            r_sum <= (w_p > r_sum) ? 64'd0 : r_sum - w_p;
                        else
                            r_sum <= w_sadd[64] ? 64'hFFFF_FFFF_FFFF_FFFF : w_sadd[63:0];
                        r_it <= 7'd125;
                    end else begin
                        r_q <= r_sum; r_rem <= '0;
                        r_den <= 64'(r_cnt - 1'b1);
                        r_it <= 7'd0;
                        r_st <= rmv_pkg::ST_DIVV;
                    end
                end
                rmv_pkg::ST_DIVV: begin
                    if (r_it == 7'd64) begin
                        if (r_cnt <= COUNT_BITS'(1)) r_var <= '0;
                        else if (w_var64[63:rmv_pkg::VAR_W] != '0) r_var <= rmv_pkg::VAR_MAX;
                        else r_var <= w_var64[rmv_pkg::VAR_W-1:0];
                        r_st <= rmv_pkg::ST_OUT; r_it <= 7'd0;
                        r_sd <= '0; r_q <= '0;
                        r_rem <= '0;
                    end else begin
                        r_rem <= w_trial[64] ? w_rs : w_trial;
                        r_q <= {r_q[62:0], ~w_trial[64]};
                        r_it <= r_it + 1'b1;
                    end
                end
                rmv_pkg::ST_OUT: begin
                    // root of {var, 8'b0}: 48 bits, two per step
                    if (r_it == 7'd0) begin
                        r_rem <= {17'd0, r_var, 8'd0};
                        r_it <= 7'd1;
                    end else if (r_it <= 7'd24) begin
                        r_rem <= {r_rem[64:48], r_rem[45:0], 2'b00};
                        if (!w_rtrial[49]) begin
                            r_q <= 64'(w_rtrial);
                            r_sd <= {r_sd[rmv_pkg::SD_W-2:0], 1'b1};
                        end else begin
                            r_q <= 64'(w_rnext);
                            r_sd <= {r_sd[rmv_pkg::SD_W-2:0], 1'b0};
                        end
                        r_it <= r_it + 1'b1;
                    end else begin
                        r_out <= {7'd0, r_ovf, 16'($unsigned(r_last)),
                                  16'($unsigned(r_max)), 16'($unsigned(r_min)),
                                  r_sd, r_var, r_mean, 24'(r_cnt)};
                        r_mv <= 1'b1;
                        r_st <= rmv_pkg::ST_IDLE;
                    end
                end
                default: r_st <= rmv_pkg::ST_IDLE;
            endcase
        end
    end
endmodule

@@ dv/tb_running_mean_variance_core.sv @@
// Testbench for running_mean_variance_core: drives samples and clears over the
// stream input and compares each result with a built-in Welford predictor.
// Depends on rmv_pkg and the core only.
module tb_running_mean_variance_core;
    localparam int CNT_W = 24;
    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic                             overflow;
        logic signed [15:0]               last_value;
        logic signed [15:0]               maximum;
        logic signed [15:0]               minimum;
        logic [rmv_pkg::SD_W-1:0]         stdev;
        logic [rmv_pkg::VAR_W-1:0]        variance;
        logic signed [rmv_pkg::MEAN_W-1:0] mean;
        logic [CNT_W-1:0]                 count;
    } t_stats;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic         s_axis_tuser = 1'b0;  // mode
    logic [15:0]  s_axis_tdata = '0;    // sample[15:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [175:0] m_axis_tdata;        // count, mean, variance, stdev, min, max, last, overflow

    running_mean_variance_core dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    logic [CNT_W-1:0]   n_acc;
    logic signed [63:0] mean_acc;
    logic [63:0]        ssd_acc;
    logic signed [15:0] min_acc, max_acc, last_acc;
    t_stats             expected_stats[$];
    int                 mismatches = 0;
    int                 stall_left = 0;
    bit                 idle_on = 1'b1;
    bit                 timed_out = 1'b0;

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void predict_stats(logic mode, logic signed [15:0] x);
        t_stats e;
        logic signed [63:0] xq, d1, d2, nm;
        logic [127:0] prod;
        logic [63:0] p, var64;
        logic [63:0] m1, m2;
        logic [63:0] sd64;
        e = '0;
        if (mode == MODE_CLEAR) begin
            n_acc = '0; mean_acc = '0; ssd_acc = '0;
            min_acc = '0; max_acc = '0; last_acc = '0;
        end else if (n_acc == CNT_SAT) begin
            e.overflow = 1'b1;
        end else begin
            xq = 64'(x) * 65536;
            last_acc = x;
            n_acc++;
            if (n_acc == 1) begin
                min_acc = x; max_acc = x; mean_acc = xq; ssd_acc = '0;
            end else begin
                if (x > max_acc) max_acc = x;
                else if (x < min_acc) min_acc = x;
                d1 = xq - mean_acc;
                nm = mean_acc + d1 / $signed({40'd0, n_acc});
                if (nm > 64'sd2147483647) nm = 64'sd2147483647;
                if (nm < -64'sd2147483648) nm = -64'sd2147483648;
                mean_acc = nm;
                d2 = xq - nm;
                m1 = d1 < 0 ? -d1 : d1;
                m2 = d2 < 0 ? -d2 : d2;
                prod = {64'd0, m1} * {64'd0, m2};
                p = (prod[127:88] != 0) ? '1 : prod[87:24];
                if ((d1 < 0) != (d2 < 0))
                    ssd_acc = p > ssd_acc ? 64'd0 : ssd_acc - p;
                else
                    ssd_acc = ('1 - ssd_acc < p) ? '1 : ssd_acc + p;
            end
        end
        var64 = '0;
        if (n_acc > 1) begin
            var64 = ssd_acc / (64'(n_acc) - 1);
            if (var64 > 64'(rmv_pkg::VAR_MAX)) var64 = 64'(rmv_pkg::VAR_MAX);
        end
        sd64 = isqrt(var64 << 8);
        e.count = n_acc;
        e.mean = mean_acc[31:0];
        e.variance = var64[rmv_pkg::VAR_W-1:0];
        e.stdev = sd64[rmv_pkg::SD_W-1:0];
        e.minimum = min_acc;
        e.maximum = max_acc;
        e.last_value = last_acc;
        expected_stats.push_back(e);
    endfunction

    task automatic send_item(logic mode, logic signed [15:0] x);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= x;
        s_axis_tuser <= mode;
        predict_stats(mode, x);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_stats.size() != 0) @(posedge i_clk);
    endtask

    // Sink side: random stalls while idle_on is set, compare against the oldest expectation.
    always @(posedge i_clk) begin
        t_stats got, e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[168:0];
            if (expected_stats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                e = expected_stats.pop_front();
                if (got !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", e, got);
                end
            end
        end
        if (!idle_on) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_item(MODE_ADD, 16'sh7FFF);
        send_item(MODE_ADD, -16'sd32768);
        send_item(MODE_ADD, 16'sh7FFF);
        send_item(MODE_ADD, -16'sd32768);
        send_item(MODE_ADD, 16'sd0);
        send_item(MODE_ADD, -16'sd1);
        send_item(MODE_CLEAR, 16'sh5A5A);
        send_item(MODE_ADD, 16'sd5);
        send_item(MODE_ADD, 16'sd5);
        send_item(MODE_ADD, 16'sd5);
        send_item(MODE_CLEAR, 16'sd0);
        send_item(MODE_ADD, -16'sd3);
        send_item(MODE_ADD, 16'sd4);
        send_item(MODE_ADD, -16'sd7);
        send_item(MODE_CLEAR, -16'sd1);
        send_item(MODE_CLEAR, 16'sd0);
    endtask

    // Hold off until the core has answered everything, then send one sample.
    task automatic test_pause();
        drain();
        send_item(MODE_ADD, 16'sd100);
    endtask

    task automatic test_random(int n);
        logic signed [15:0] x;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: x = 16'($urandom);
                1: x = 16'($urandom_range(0, 15) - 8);
                2: x = $urandom_range(0, 1) ? 16'sh7FFF : -16'sd32768;
                default: x = 16'(1000 + $urandom_range(0, 63));
            endcase
            send_item($urandom_range(0, 59) == 0 ? MODE_CLEAR : MODE_ADD, x);
        end
    endtask

    initial begin
        n_acc = '0; mean_acc = '0; ssd_acc = '0;
        min_acc = '0; max_acc = '0; last_acc = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_pause();
        test_random(1600);
        idle_on = 1'b0;
        test_random(330);
        drain();
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && !timed_out)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20000000;
        timed_out = 1'b1;
        $display("Some tests failed");
        $finish;
    end
endmodule
